@@ rtl/ntc_pkg.sv @@
`timescale 1ns / 1ps

package ntc_pkg;

  // Converter resolution; full scale is the all-ones code.
  localparam int AdcBits   = 12;
  localparam int PBits     = $clog2(AdcBits);
  localparam int FracBits  = 16;
  localparam int LogSteps  = FracBits;
  localparam int LgW       = PBits + FracBits;
  localparam int CfgW      = 20;
  localparam int CalPBits  = $clog2(CfgW);
  localparam int CalLgW    = CalPBits + FracBits;
  localparam int KW        = CalLgW + 1;
  localparam int LW        = KW + 2;
  localparam int MantW     = 31;
  localparam int ProdW     = LW + 24;
  localparam int MagW      = ProdW - 1;
  localparam int SW        = ProdW + 1;
  localparam int QW        = 18;
  localparam int NumW      = 47;
  localparam int I0W       = 35;
  localparam int T0W       = 16;
  localparam int BetaW     = 14;
  localparam int NomTW     = 15;
  localparam int TempW     = 18;

  localparam logic [NumW-1:0] HundredQ40 = 47'd109951162777600;
  localparam logic [24:0]     Ln2Q24     = 25'd11629080;
  localparam int ZeroCK  = 27315;
  localparam int TempMin = -27315;
  localparam int TempMax = 100000;

  localparam logic [CfgW-1:0]  FixedRReset = 20'd10000;
  localparam logic [CfgW-1:0]  NomRReset   = 20'd11000;
  localparam logic [BetaW-1:0] BetaReset   = 14'd3950;
  localparam logic [NomTW-1:0] NomTReset   = 15'd2500;

  typedef enum logic [1:0] {
    RegFixedR = 2'd0,
    RegNomR   = 2'd1,
    RegBeta   = 2'd2,
    RegNomT   = 2'd3
  } ntc_reg_t;

  // Side information that travels with every pipeline beat.
  typedef struct packed {
    logic vld;
    logic ok;
    logic ch;
  } ntc_tag_t;

  // Values derived from the configuration registers.
  typedef struct packed {
    logic             busy;
    logic [KW-1:0]    k;
    logic [I0W-1:0]   i0;
    logic [BetaW-1:0] beta;
  } ntc_cal_t;

  function automatic logic [CalPBits-1:0] ntc_msb(input logic [CfgW-1:0] x);
    logic [CalPBits-1:0] p;
    p = '0;
    for (int i = 0; i < CfgW; i++) begin
      if (x[i]) p = CalPBits'(i);
    end
    return p;
  endfunction

  // Places the leading one of x at bit 30 (Q1.30 mantissa).
  function automatic logic [MantW-1:0] ntc_norm(input logic [CfgW-1:0] x,
                                                input logic [CalPBits-1:0] p);
    logic [MantW+CfgW-1:0] w;
    w = {{MantW{1'b0}}, x} << (CalPBits'(MantW - 1) - p);
    return w[MantW-1:0];
  endfunction

  // One squaring round: returns {fraction bit, next mantissa}.
  function automatic logic [MantW:0] ntc_sq(input logic [MantW-1:0] m);
    logic [2*MantW-1:0] pr;
    logic [MantW:0]     t;
    pr = m * m;
    t  = pr[2*MantW-1:MantW-1];
    if (t[MantW]) return {1'b1, t[MantW:1]};
    else return {1'b0, t[MantW-1:0]};
  endfunction

endpackage

@@ rtl/ntc_thermistor_temperature.sv @@
`timescale 1ns / 1ps
// Throughput: one beat per cycle; a stalled output freezes the whole pipeline.
// Reset (rst_n, synchronous, active low) empties the pipeline, loads the default
// registers and runs a calibration (two logarithms and one reciprocal), which
// also follows every configuration write; no input is taken meanwhile.
module ntc_thermistor_temperature (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream. tdata: [11:0] raw_code, [15:12] zero. tuser: [0] sensor_channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        in_tuser,
  // Result stream. tdata: [17:0] temp_centi_c, [23:18] zero.
  // tuser: [0] reading_valid, [1] result_channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  output logic [1:0]  out_tuser,
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  ntc_pkg::ntc_cal_t                 cal;
  logic                              en;
  logic [ntc_pkg::LgW-1:0]           lg_c, lg_d;
  ntc_pkg::ntc_tag_t                 lg_tag, l_tag_r, bd_tag, td_tag;
  logic signed [ntc_pkg::LW-1:0]     l_r;
  logic signed [ntc_pkg::ProdW-1:0]  t1;
  logic [ntc_pkg::QW-1:0]            q;
  logic                              sat;
  logic signed [ntc_pkg::QW+1:0]     tk;
  logic signed [ntc_pkg::TempW-1:0]  temp;
  logic                              out_vld_r, out_ok_r, out_ch_r;
  logic [ntc_pkg::TempW-1:0]         out_temp_r;

  // Every stage advances together whenever the output register can move on.
  assign en        = !out_vld_r || out_tready;
  assign in_tready = en && !cal.busy;

  // The derived constants log2(R_fixed/R0) and 1/T0 are worked out here.
  ntc_cal u_cal (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cal       (cal)
  );

  // Base-2 logarithms of the code and of its distance to full scale.
  ntc_log_pipe u_log (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_tvalid && in_tready),
    .code   (in_tdata[ntc_pkg::AdcBits-1:0]),
    .ch     (in_tuser),
    .lg_c   (lg_c),
    .lg_d   (lg_d),
    .tag    (lg_tag)
  );

  // Log of the resistance ratio R/R0, in Q16 base-2 units.
  always_ff @(posedge clk) begin
    if (!rst_n) l_tag_r.vld <= 1'b0;
    else if (en) l_tag_r <= lg_tag;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l_r <= ntc_pkg::LW'($signed(cal.k)) + ntc_pkg::LW'(lg_c) - ntc_pkg::LW'(lg_d);
    end
  end

  // Scale to a natural log and divide by B, giving the Q40 change of 1/T.
  ntc_beta_div u_bdiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .l      (l_r),
    .tag_in (l_tag_r),
    .beta   (cal.beta),
    .t1     (t1),
    .tag    (bd_tag)
  );

  // Add 1/T0 and take the rounded reciprocal back to hundredths of a kelvin.
  ntc_temp_div u_tdiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .t1     (t1),
    .tag_in (bd_tag),
    .i0     (cal.i0),
    .q      (q),
    .sat    (sat),
    .tag    (td_tag)
  );

  // Convert to Celsius. Codes at either rail report absolute zero and no
  // reading; a non-positive or tiny reciprocal saturates at the top of range.
  always_comb begin
    tk = $signed({2'b00, q}) - (ntc_pkg::QW+2)'(ntc_pkg::ZeroCK);
    if (!td_tag.ok) temp = ntc_pkg::TempW'(ntc_pkg::TempMin);
    else if (sat || tk > (ntc_pkg::QW+2)'(ntc_pkg::TempMax))
      temp = ntc_pkg::TempW'(ntc_pkg::TempMax);
    else temp = tk[ntc_pkg::TempW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= td_tag.vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_temp_r <= temp;
      out_ok_r   <= td_tag.ok;
      out_ch_r   <= td_tag.ch;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'b000000, out_temp_r};
  assign out_tuser  = {out_ch_r, out_ok_r};

  // No sample may enter while the derived constants are being recomputed.
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cal.busy |-> !in_tready)
    else $error("input accepted during calibration");

  // A configuration write starts a recalculation that holds off input.
  a_cfg_starts_cal: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> !in_tready)
    else $error("configuration write did not start calibration");

  // A reading flagged invalid always carries absolute zero.
  a_invalid_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata[17:0] == 18'(ntc_pkg::TempMin)))
    else $error("invalid reading with a temperature other than absolute zero");

endmodule

@@ rtl/ntc_cal.sv @@
`timescale 1ns / 1ps

module ntc_cal (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [ntc_pkg::CfgW-1:0]  cfg_data,
  output ntc_pkg::ntc_cal_t         cal
);

  typedef enum logic [2:0] {C_LOAD, C_SQ, C_DPREP, C_DIV, C_IDLE} cstate_t;

  cstate_t                          state_r;
  logic                             sel_r;
  logic [5:0]                       cnt_r;
  logic [ntc_pkg::CfgW-1:0]         fixed_r, nomr_r;
  logic [ntc_pkg::BetaW-1:0]        beta_r;
  logic [ntc_pkg::NomTW-1:0]        nomt_r;
  logic [ntc_pkg::MantW-1:0]        m_r;
  logic [ntc_pkg::CalPBits-1:0]     p_r;
  logic [ntc_pkg::FracBits-1:0]     frac_r;
  logic [ntc_pkg::CalLgW-1:0]       lgrf_r;
  logic [ntc_pkg::KW-1:0]           k_r;
  logic [ntc_pkg::T0W-1:0]          t0_r;
  logic [ntc_pkg::NumW-1:0]         num_r;
  logic [ntc_pkg::T0W-1:0]          rem_r;
  logic [ntc_pkg::I0W-1:0]          q_r, i0_r;

  logic [ntc_pkg::CfgW-1:0]         x;
  logic [ntc_pkg::CalPBits-1:0]     xp;
  logic [ntc_pkg::MantW:0]          sq;
  logic [ntc_pkg::FracBits-1:0]     frac_nxt;
  logic [ntc_pkg::CalLgW-1:0]       lg_nxt;
  logic signed [ntc_pkg::T0W:0]     t0s;
  logic [ntc_pkg::T0W:0]            dt;
  logic                             qb;

  always_comb begin
    x = sel_r ? nomr_r : fixed_r;
    if (x == '0) x = ntc_pkg::CfgW'(1);
    xp       = ntc_pkg::ntc_msb(x);
    sq       = ntc_pkg::ntc_sq(m_r);
    frac_nxt = {frac_r[ntc_pkg::FracBits-2:0], sq[ntc_pkg::MantW]};
    lg_nxt   = {p_r, frac_nxt};
    t0s      = (ntc_pkg::T0W+1)'($signed(nomt_r)) + (ntc_pkg::T0W+1)'(ntc_pkg::ZeroCK);
    dt       = {rem_r, num_r[ntc_pkg::NumW-1]};
    qb       = (dt >= {1'b0, t0_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_LOAD;
      sel_r   <= 1'b0;
      cnt_r   <= '0;
      fixed_r <= ntc_pkg::FixedRReset;
      nomr_r  <= ntc_pkg::NomRReset;
      beta_r  <= ntc_pkg::BetaReset;
      nomt_r  <= ntc_pkg::NomTReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (ntc_pkg::ntc_reg_t'(cfg_index))
        ntc_pkg::RegFixedR: fixed_r <= cfg_data;
        ntc_pkg::RegNomR:   nomr_r  <= cfg_data;
        ntc_pkg::RegBeta:   beta_r  <= cfg_data[ntc_pkg::BetaW-1:0];
        ntc_pkg::RegNomT:   nomt_r  <= cfg_data[ntc_pkg::NomTW-1:0];
      endcase
      state_r <= C_LOAD;
      sel_r   <= 1'b0;
    end else begin
      unique case (state_r)
        C_LOAD: begin
          p_r     <= xp;
          m_r     <= ntc_pkg::ntc_norm(x, xp);
          frac_r  <= '0;
          cnt_r   <= '0;
          state_r <= C_SQ;
        end
        C_SQ: begin
          m_r    <= sq[ntc_pkg::MantW-1:0];
          frac_r <= frac_nxt;
          cnt_r  <= cnt_r + 6'd1;
          if (cnt_r == 6'(ntc_pkg::LogSteps - 1)) begin
            if (!sel_r) begin
              lgrf_r  <= lg_nxt;
              sel_r   <= 1'b1;
              state_r <= C_LOAD;
            end else begin
              k_r     <= {1'b0, lgrf_r} - {1'b0, lg_nxt};
              state_r <= C_DPREP;
            end
          end
        end
        C_DPREP: begin
          t0_r    <= t0s[ntc_pkg::T0W-1:0];
          num_r   <= ntc_pkg::HundredQ40 + ntc_pkg::NumW'(t0s[ntc_pkg::T0W-1:1]);
          rem_r   <= '0;
          q_r     <= '0;
          cnt_r   <= '0;
          state_r <= C_DIV;
        end
        C_DIV: begin
          rem_r <= qb ? ntc_pkg::T0W'(dt - {1'b0, t0_r}) : dt[ntc_pkg::T0W-1:0];
          num_r <= {num_r[ntc_pkg::NumW-2:0], 1'b0};
          q_r   <= {q_r[ntc_pkg::I0W-2:0], qb};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(ntc_pkg::NumW - 1)) begin
            i0_r    <= {q_r[ntc_pkg::I0W-2:0], qb};
            state_r <= C_IDLE;
          end
        end
        C_IDLE: state_r <= C_IDLE;
        default: state_r <= C_LOAD;
      endcase
    end
  end

  assign cfg_ready = (state_r == C_IDLE);
  assign cal.busy  = (state_r != C_IDLE);
  assign cal.k     = k_r;
  assign cal.i0    = i0_r;
  assign cal.beta  = (beta_r == '0) ? ntc_pkg::BetaW'(1) : beta_r;

endmodule

@@ rtl/ntc_log_pipe.sv @@
`timescale 1ns / 1ps

module ntc_log_pipe (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [ntc_pkg::AdcBits-1:0] code,
  input  logic                        ch,
  output logic [ntc_pkg::LgW-1:0]     lg_c,
  output logic [ntc_pkg::LgW-1:0]     lg_d,
  output ntc_pkg::ntc_tag_t           tag
);

  localparam int N = ntc_pkg::LogSteps;

  ntc_pkg::ntc_tag_t               tag_r  [0:N];
  logic [ntc_pkg::MantW-1:0]       mc_r   [0:N];
  logic [ntc_pkg::MantW-1:0]       md_r   [0:N];
  logic [ntc_pkg::PBits-1:0]       pc_r   [0:N];
  logic [ntc_pkg::PBits-1:0]       pd_r   [0:N];
  logic [ntc_pkg::FracBits-1:0]    fc_r   [0:N];
  logic [ntc_pkg::FracBits-1:0]    fd_r   [0:N];

  logic [ntc_pkg::AdcBits-1:0]     dcode;
  logic [ntc_pkg::CalPBits-1:0]    pc, pd;
  logic [ntc_pkg::CfgW-1:0]        xc, xd;

  always_comb begin
    dcode = '1 - code;
    xc    = ntc_pkg::CfgW'(code);
    xd    = ntc_pkg::CfgW'(dcode);
    pc    = ntc_pkg::ntc_msb(xc);
    pd    = ntc_pkg::ntc_msb(xd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) tag_r[0].vld <= 1'b0;
    else if (en) begin
      tag_r[0].vld <= in_vld;
      tag_r[0].ok  <= (code != '0) && (code != '1);
      tag_r[0].ch  <= ch;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mc_r[0] <= ntc_pkg::ntc_norm(xc, pc);
      md_r[0] <= ntc_pkg::ntc_norm(xd, pd);
      pc_r[0] <= pc[ntc_pkg::PBits-1:0];
      pd_r[0] <= pd[ntc_pkg::PBits-1:0];
      fc_r[0] <= '0;
      fd_r[0] <= '0;
    end
  end

  for (genvar i = 1; i <= N; i++) begin : g_sq
    logic [ntc_pkg::MantW:0] sc, sd;
    assign sc = ntc_pkg::ntc_sq(mc_r[i-1]);
    assign sd = ntc_pkg::ntc_sq(md_r[i-1]);

    always_ff @(posedge clk) begin
      if (!rst_n) tag_r[i].vld <= 1'b0;
      else if (en) tag_r[i] <= tag_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        mc_r[i] <= sc[ntc_pkg::MantW-1:0];
        md_r[i] <= sd[ntc_pkg::MantW-1:0];
        pc_r[i] <= pc_r[i-1];
        pd_r[i] <= pd_r[i-1];
        fc_r[i] <= {fc_r[i-1][ntc_pkg::FracBits-2:0], sc[ntc_pkg::MantW]};
        fd_r[i] <= {fd_r[i-1][ntc_pkg::FracBits-2:0], sd[ntc_pkg::MantW]};
      end
    end
  end

  assign lg_c = {pc_r[N], fc_r[N]};
  assign lg_d = {pd_r[N], fd_r[N]};
  assign tag  = tag_r[N];

endmodule

@@ rtl/ntc_beta_div.sv @@
`timescale 1ns / 1ps

module ntc_beta_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic signed [ntc_pkg::LW-1:0]  l,
  input  ntc_pkg::ntc_tag_t              tag_in,
  input  logic [ntc_pkg::BetaW-1:0]      beta,
  output logic signed [ntc_pkg::ProdW-1:0] t1,
  output ntc_pkg::ntc_tag_t              tag
);

  localparam int N = ntc_pkg::MagW;

  ntc_pkg::ntc_tag_t                 ptag_r;
  logic signed [ntc_pkg::ProdW-1:0]  prod_r;
  ntc_pkg::ntc_tag_t                 tag_r [0:N];
  logic                              neg_r [0:N];
  logic [ntc_pkg::BetaW-1:0]         rem_r [0:N];
  logic [N-1:0]                      dq_r  [0:N];

  logic signed [ntc_pkg::ProdW-1:0]  prod;
  logic signed [ntc_pkg::ProdW-1:0]  mag;
  logic signed [ntc_pkg::ProdW-1:0]  qs;

  always_comb begin
    prod = ntc_pkg::ProdW'(l) * ntc_pkg::ProdW'($signed({1'b0, ntc_pkg::Ln2Q24}));
    mag  = prod_r[ntc_pkg::ProdW-1] ? -prod_r : prod_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptag_r.vld   <= 1'b0;
      tag_r[0].vld <= 1'b0;
    end else if (en) begin
      ptag_r   <= tag_in;
      tag_r[0] <= ptag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r   <= prod;
      neg_r[0] <= prod_r[ntc_pkg::ProdW-1];
      rem_r[0] <= '0;
      dq_r[0]  <= mag[N-1:0];
    end
  end

  for (genvar i = 1; i <= N; i++) begin : g_div
    logic [ntc_pkg::BetaW:0] t;
    logic                    ge;
    assign t  = {rem_r[i-1], dq_r[i-1][N-1]};
    assign ge = (t >= {1'b0, beta});

    always_ff @(posedge clk) begin
      if (!rst_n) tag_r[i].vld <= 1'b0;
      else if (en) tag_r[i] <= tag_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[i] <= neg_r[i-1];
        rem_r[i] <= ge ? ntc_pkg::BetaW'(t - {1'b0, beta}) : t[ntc_pkg::BetaW-1:0];
        dq_r[i]  <= {dq_r[i-1][N-2:0], ge};
      end
    end
  end

  // Quotient truncates toward zero, so the sign is applied to the magnitude.
  assign qs  = $signed({1'b0, dq_r[N]});
  assign t1  = neg_r[N] ? -qs : qs;
  assign tag = tag_r[N];

endmodule

@@ rtl/ntc_temp_div.sv @@
`timescale 1ns / 1ps

module ntc_temp_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic signed [ntc_pkg::ProdW-1:0] t1,
  input  ntc_pkg::ntc_tag_t                tag_in,
  input  logic [ntc_pkg::I0W-1:0]          i0,
  output logic [ntc_pkg::QW-1:0]           q,
  output logic                             sat,
  output ntc_pkg::ntc_tag_t                tag
);

  localparam int N  = ntc_pkg::QW;
  localparam int DW = ntc_pkg::ProdW;

  ntc_pkg::ntc_tag_t               stag_r;
  logic signed [ntc_pkg::SW-1:0]   s_r;
  ntc_pkg::ntc_tag_t               tag_r [0:N];
  logic                            sat_r [0:N];
  logic [DW-1:0]                   d_r   [0:N];
  logic [DW-1:0]                   rem_r [0:N];
  logic [N-1:0]                    q_r   [0:N];

  logic          pos;
  logic [DW-1:0] d, num;
  logic          ovf;

  always_comb begin
    pos = !s_r[ntc_pkg::SW-1] && (s_r != '0);
    d   = s_r[DW-1:0];
    num = DW'(ntc_pkg::HundredQ40) + {1'b0, d[DW-1:1]};
    ovf = ({{N{1'b0}}, num} >= {d, {N{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stag_r.vld   <= 1'b0;
      tag_r[0].vld <= 1'b0;
    end else if (en) begin
      stag_r   <= tag_in;
      tag_r[0] <= stag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r      <= ntc_pkg::SW'(t1) + ntc_pkg::SW'(i0);
      sat_r[0] <= !pos || ovf;
      d_r[0]   <= d;
      rem_r[0] <= num;
      q_r[0]   <= '0;
    end
  end

  for (genvar i = 1; i <= N; i++) begin : g_div
    logic [DW+N-2:0] dsh;
    logic            ge;
    assign dsh = (DW+N-1)'(d_r[i-1]) << (N - i);
    assign ge  = ((DW+N-1)'(rem_r[i-1]) >= dsh);

    always_ff @(posedge clk) begin
      if (!rst_n) tag_r[i].vld <= 1'b0;
      else if (en) tag_r[i] <= tag_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sat_r[i] <= sat_r[i-1];
        d_r[i]   <= d_r[i-1];
        rem_r[i] <= ge ? rem_r[i-1] - dsh[DW-1:0] : rem_r[i-1];
        q_r[i]   <= {q_r[i-1][N-2:0], ge};
      end
    end
  end

  assign q   = q_r[N];
  assign sat = sat_r[N];
  assign tag = tag_r[N];

endmodule

@@ tb/tb_ntc_thermistor_temperature.sv @@
`timescale 1ns / 1ps

module tb_ntc_thermistor_temperature;

  localparam int FullScale = (1 << ntc_pkg::AdcBits) - 1;
  localparam int SettleCycles = 200;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [11:0] raw_code, [15:12] zero
  logic        in_tuser;   // [0] sensor_channel
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [17:0] temp_centi_c, [23:18] zero
  logic [1:0]  out_tuser;  // [0] reading_valid, [1] result_channel
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [19:0] cfg_data;

  ntc_thermistor_temperature dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // One expected reading, kept in the order its beat was accepted.
  typedef struct {
    logic signed [ntc_pkg::TempW-1:0] temp;
    logic                             valid;
    logic                             chan;
  } reading_t;

  // Local copy of the calibration registers.
  logic [ntc_pkg::CfgW-1:0]         rfix_q;
  logic [ntc_pkg::CfgW-1:0]         rnom_q;
  logic [ntc_pkg::BetaW-1:0]        beta_q;
  logic signed [ntc_pkg::NomTW-1:0] tnom_q;

  reading_t pending_readings[$];
  int mismatches;
  int beats_out;
  int invalid_seen;
  int saturated_seen;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Base-2 logarithm with 16 fraction bits by repeated squaring in Q1.30.
  function automatic longint lg_q16(input longint unsigned x);
    longint unsigned mant;
    int p;
    longint frac;
    if (x == 0) x = 1;
    p = 0;
    frac = 0;
    while (p < 40 && (x >> (p + 1)) != 0) p++;
    mant = x << (30 - p);
    for (int i = 0; i < 16; i++) begin
      mant = (mant * mant) >> 30;
      frac = frac << 1;
      if (mant >= (64'd2 << 30)) begin
        mant = mant >> 1;
        frac = frac | 1;
      end
    end
    return (longint'(p) << 16) + frac;
  endfunction

  function automatic reading_t thermistor_reading(input logic [11:0] code, input logic chan);
    reading_t r;
    longint rf, r0, b, l, t1, i0, s, tk, t;
    longint unsigned hundred, t0;
    hundred = 64'd100 << 40;
    r.chan = chan;
    if (code == 0 || code >= FullScale) begin
      r.temp = ntc_pkg::TempMin;
      r.valid = 1'b0;
      return r;
    end
    rf = (rfix_q == 0) ? 1 : rfix_q;
    r0 = (rnom_q == 0) ? 1 : rnom_q;
    b  = (beta_q == 0) ? 1 : beta_q;
    l  = lg_q16(rf) + lg_q16(code) - lg_q16(FullScale - code) - lg_q16(r0);
    t1 = (l * 64'sd11629080) / b;  // SV signed division truncates toward zero
    t0 = longint'(tnom_q) + ntc_pkg::ZeroCK;
    i0 = (hundred + t0 / 2) / t0;
    s  = t1 + i0;
    r.valid = 1'b1;
    if (s <= 0) t = ntc_pkg::TempMax;
    else begin
      tk = (hundred + longint'(s) / 2) / s;
      t = tk - ntc_pkg::ZeroCK;
      if (t > ntc_pkg::TempMax) t = ntc_pkg::TempMax;
      if (t < ntc_pkg::TempMin) t = ntc_pkg::TempMin;
    end
    r.temp = t[ntc_pkg::TempW-1:0];
    return r;
  endfunction

  // Leaves cfg_valid high; the caller drops it once the last write is through.
  task automatic write_reg(input ntc_pkg::ntc_reg_t idx, input logic [19:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      ntc_pkg::RegFixedR: rfix_q = value;
      ntc_pkg::RegNomR:   rnom_q = value;
      ntc_pkg::RegBeta:   beta_q = value[ntc_pkg::BetaW-1:0];
      ntc_pkg::RegNomT:   tnom_q = value[ntc_pkg::NomTW-1:0];
      default: ;
    endcase
  endtask

  // Drains outstanding results and the pipeline before touching configuration.
  task automatic wait_idle();
    int guard;
    guard = 0;
    while (pending_readings.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic send_code(input logic [11:0] code, input logic chan,
                           input bit has_hint, input reading_t hint);
    reading_t exp_r;
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, code};
    in_tuser  <= chan;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    exp_r = thermistor_reading(code, chan);
    if (has_hint && (hint.temp != exp_r.temp || hint.valid != exp_r.valid)) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row disagrees with prediction: code %0d hint %0d/%0b pred %0d/%0b",
                 code, hint.temp, hint.valid, exp_r.temp, exp_r.valid);
    end
    pending_readings.push_back(has_hint ? hint : exp_r);
    if ($urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3))
        @(posedge clk);
    end
  endtask

  // Result side: random stalls, compare each beat with the oldest expectation.
  initial begin
    int   stall_left;
    logic rdy;
    stall_left = 0;
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      // Most stall lengths come from the short range; now and then the sink holds off for longer.
      if (stall_left > 0) begin
        rdy = 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
        rdy = 1'b0;
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      end else begin
        rdy = 1'b1;
      end
      out_tready <= rdy;
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        reading_t e;
        beats_out++;
        if (pending_readings.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %h/%b", out_tdata, out_tuser);
        end else begin
          e = pending_readings.pop_front();
          if (!out_tuser[0]) invalid_seen++;
          if (out_tdata[17:0] == 18'(ntc_pkg::TempMax)) saturated_seen++;
          if (out_tdata[17:0] !== e.temp || out_tdata[23:18] !== 6'd0 ||
              out_tuser[0] !== e.valid || out_tuser[1] !== e.chan) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp temp %0d valid %b ch %b, got temp %0d valid %b ch %b",
                       e.temp, e.valid, e.chan, $signed(out_tdata[17:0]),
                       out_tuser[0], out_tuser[1]);
          end
        end
      end
    end
  end

  // Directed rows: code, channel, whether a literal expectation is given, and that value.
  typedef struct {
    logic [11:0] code;
    logic        chan;
    bit          fixed;
    int          temp;
    logic        valid;
  } row_t;

  row_t dir_rows[] = '{
    '{12'd0,    1'b0, 1, ntc_pkg::TempMin, 1'b0},
    '{12'd4095, 1'b1, 1, ntc_pkg::TempMin, 1'b0},
    '{12'd1,    1'b1, 0, 0, 1'b1},
    '{12'd4094, 1'b0, 0, 0, 1'b1},
    '{12'd2048, 1'b0, 0, 0, 1'b1},
    '{12'd2047, 1'b1, 0, 0, 1'b1},
    '{12'd1950, 1'b0, 0, 0, 1'b1},
    '{12'd2730, 1'b1, 0, 0, 1'b1},
    '{12'd1365, 1'b0, 0, 0, 1'b1},
    '{12'd100,  1'b1, 0, 0, 1'b1},
    '{12'd3995, 1'b0, 0, 0, 1'b1},
    '{12'd3000, 1'b1, 0, 0, 1'b1}
  };

  // Calibration settings per phase, including the register extremes and zero values.
  task automatic set_phase(input int ph);
    case (ph)
      0: ;
      1: begin
        write_reg(ntc_pkg::RegFixedR, 20'd1000000);
        write_reg(ntc_pkg::RegNomR, 20'd1);
        write_reg(ntc_pkg::RegBeta, 14'd1000);
        write_reg(ntc_pkg::RegNomT, 20'(15'(-5500)));
      end
      2: begin
        write_reg(ntc_pkg::RegFixedR, 20'd1);
        write_reg(ntc_pkg::RegNomR, 20'd1000000);
        write_reg(ntc_pkg::RegBeta, 14'd10000);
        write_reg(ntc_pkg::RegNomT, 20'(15'd15000));
      end
      3: begin
        write_reg(ntc_pkg::RegFixedR, 20'd0);
        write_reg(ntc_pkg::RegNomR, 20'd0);
        write_reg(ntc_pkg::RegBeta, 14'd0);
        write_reg(ntc_pkg::RegNomT, 20'(15'(-16384)));
      end
      4: begin
        write_reg(ntc_pkg::RegFixedR, 20'hFFFFF);
        write_reg(ntc_pkg::RegNomR, 20'd4700);
        write_reg(ntc_pkg::RegBeta, 14'h3FFF);
        write_reg(ntc_pkg::RegNomT, 20'(15'h3FFF));
      end
      default: begin
        write_reg(ntc_pkg::RegFixedR, 20'($urandom_range(1, 1000000)));
        write_reg(ntc_pkg::RegNomR, 20'($urandom_range(1, 1000000)));
        write_reg(ntc_pkg::RegBeta, 20'($urandom_range(1000, 10000)));
        write_reg(ntc_pkg::RegNomT, 20'(15'($signed($urandom_range(0, 20500)) - 5500)));
      end
    endcase
  endtask

  initial begin
    reading_t hint;
    logic [11:0] code;
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = 1'b0;
    cfg_valid = 1'b0; cfg_index = ntc_pkg::RegFixedR; cfg_data = '0;
    mismatches = 0; beats_out = 0; invalid_seen = 0; saturated_seen = 0;
    rfix_q = ntc_pkg::FixedRReset; rnom_q = ntc_pkg::NomRReset;
    beta_q = ntc_pkg::BetaReset;   tnom_q = ntc_pkg::NomTReset;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table at reset settings.
    foreach (dir_rows[i]) begin
      hint.temp = dir_rows[i].temp[ntc_pkg::TempW-1:0];
      hint.valid = dir_rows[i].valid;
      hint.chan = dir_rows[i].chan;
      send_code(dir_rows[i].code, dir_rows[i].chan, dir_rows[i].fixed, hint);
    end
    in_tvalid <= 1'b0;

    // Random phases: mostly mid-range codes, with edges and full-range noise mixed in.
    for (int ph = 0; ph < 10; ph++) begin
      wait_idle();
      set_phase(ph);
      cfg_valid <= 1'b0;
      for (int n = 0; n < 175; n++) begin
        case ($urandom_range(0, 9))
          0: code = 12'($urandom_range(0, 3)) | (($urandom_range(0, 1) == 1) ? 12'hFFC : 12'h0);
          1, 2: code = 12'($urandom);
          default: code = 12'($urandom_range(200, 3900));
        endcase
        send_code(code, 1'($urandom), 0, hint);
      end
      in_tvalid <= 1'b0;
    end

    wait_idle();
    $display("Covered %0d result beats over 10 register settings,", beats_out);
    $display("including %0d invalid codes and %0d readings at the upper clamp.",
             invalid_seen, saturated_seen);
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule
